@@ design/ramr_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational add/multiply/reduce package
// Shared widths, command codes, payload structs and controller interface.
// ----------------------------------------------------------------------------
package ramr_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int NUM_W         = 2 * OPERAND_WIDTH + 1;
    localparam int DEN_W         = 2 * OPERAND_WIDTH;
    localparam int CNT_W         = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_MUL  = 2'd1,
        CMD_CMP  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic [OPERAND_WIDTH-1:0] a_num;
        logic [OPERAND_WIDTH-1:0] a_den;
        logic [OPERAND_WIDTH-1:0] b_num;
        logic [OPERAND_WIDTH-1:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0] res_num;
        logic [DEN_W-1:0] res_den;
        logic             equal;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic load_prod;
        logic load_sum;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic gcd_done;
        logic div_last;
    } t_dp_sts;

endpackage

@@ design/ramr_dpath.sv @@
// ----------------------------------------------------------------------------
// Rational add/multiply/reduce datapath
// Products, raw sum, binary GCD and two restoring dividers sharing one divisor.
// ----------------------------------------------------------------------------
module ramr_dpath
    import ramr_pkg::*;
(
    input  logic      i_clk,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_item o_out
);

    t_in_item         r_in;
    logic [PROD_W-1:0] r_p_anbd;
    logic [PROD_W-1:0] r_p_adbn;
    logic [PROD_W-1:0] r_p_anbn;
    logic [PROD_W-1:0] r_p_adbd;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_x;
    logic [NUM_W-1:0] r_y;
    logic [CNT_W-1:0] r_k;
    logic [NUM_W-1:0] r_g;
    logic [NUM_W-1:0] r_qn;
    logic [NUM_W-1:0] r_qd;
    logic [NUM_W-1:0] r_rn;
    logic [NUM_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    t_out_item        r_out;

    logic [NUM_W-1:0] n_num;
    logic [NUM_W:0]   w_shn;
    logic [NUM_W:0]   w_shd;
    logic [NUM_W:0]   w_difn;
    logic [NUM_W:0]   w_difd;
    logic             w_arith;

    assign w_arith = (r_in.cmd == CMD_ADD) || (r_in.cmd == CMD_MUL);

    always_comb begin
        unique case (r_in.cmd)
            CMD_ADD: n_num = NUM_W'(r_p_anbd) + NUM_W'(r_p_adbn);
            CMD_MUL: n_num = NUM_W'(r_p_anbn);
            default: n_num = '0;
        endcase
    end

    assign w_shn  = {r_rn, r_qn[NUM_W-1]};
    assign w_shd  = {r_rd, r_qd[NUM_W-1]};
    assign w_difn = w_shn - {1'b0, r_g};
    assign w_difd = w_shd - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.load_prod) begin
            r_p_anbd <= PROD_W'(r_in.a_num) * PROD_W'(r_in.b_den);
            r_p_adbn <= PROD_W'(r_in.a_den) * PROD_W'(r_in.b_num);
            r_p_anbn <= PROD_W'(r_in.a_num) * PROD_W'(r_in.b_num);
            r_p_adbd <= PROD_W'(r_in.a_den) * PROD_W'(r_in.b_den);
        end
        if (i_cmd.load_sum) begin
            r_num <= n_num;
            r_den <= DEN_W'(r_p_adbd);
            r_x   <= n_num;
            r_y   <= NUM_W'(r_p_adbd);
            r_k   <= '0;
        end
        if (i_cmd.gcd_step) begin
            priority if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + CNT_W'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_x << r_k;
            r_qn  <= r_num;
            r_qd  <= NUM_W'(r_den);
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (!w_difn[NUM_W]) begin
                r_rn <= w_difn[NUM_W-1:0];
                r_qn <= {r_qn[NUM_W-2:0], 1'b1};
            end else begin
                r_rn <= w_shn[NUM_W-1:0];
                r_qn <= {r_qn[NUM_W-2:0], 1'b0};
            end
            if (!w_difd[NUM_W]) begin
                r_rd <= w_difd[NUM_W-1:0];
                r_qd <= {r_qd[NUM_W-2:0], 1'b1};
            end else begin
                r_rd <= w_shd[NUM_W-1:0];
                r_qd <= {r_qd[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            if (!w_arith) begin
                r_out.res_num <= '0;
                r_out.res_den <= '0;
                r_out.equal   <= (r_in.cmd == CMD_CMP) && (r_in.a_num == r_in.b_num)
                                 && (r_in.a_den == r_in.b_den);
            end else if (o_sts.skip) begin
                r_out.res_num <= r_num;
                r_out.res_den <= r_den;
                r_out.equal   <= 1'b0;
            end else begin
                r_out.res_num <= r_qn;
                r_out.res_den <= r_qd[DEN_W-1:0];
                r_out.equal   <= 1'b0;
            end
        end
    end

    assign o_sts.skip     = !w_arith || (r_num == '0) || (r_den == '0);
    assign o_sts.gcd_done = (r_x == r_y);
    assign o_sts.div_last = (r_cnt == CNT_W'(1));
    assign o_out          = r_out;

endmodule

@@ design/ramr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rational add/multiply/reduce controller
// Sequences one item through product, sum, GCD, division and output load.
// ----------------------------------------------------------------------------
module ramr_ctrl
    import ramr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.load_prod = 1'b1;
                n_state         = S_SUM;
            end
            S_SUM: begin
                o_cmd.load_sum = 1'b1;
                n_state        = S_GCD;
            end
            S_GCD: begin
                priority if (i_sts.skip) begin
                    n_state = S_FIN;
                end else if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ design/rational_add_mul_reduce.sv @@
// ----------------------------------------------------------------------------
// Compare, unused commands and zero numerators or denominators skip the GCD
// and division; other items take the binary GCD steps, one step a cycle, and
// then the restoring division of the 33-bit numerator and denominator.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is loaded into the output register, which holds it until taken.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Rational add/multiply/reduce top level
// Adds or multiplies two unsigned fractions and reduces the result by its GCD, or compares their fields for equality.
// ----------------------------------------------------------------------------
module rational_add_mul_reduce
    import ramr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ramr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ramr_dpath u_dpath (
        .i_clk (i_clk),
        .i_in  (i_in),
        .i_cmd (w_cmd),
        .o_sts (w_sts),
        .o_out (o_out)
    );

endmodule

@@ design/ramr_checker.sv @@
// ----------------------------------------------------------------------------
// Rational add/multiply/reduce port checker
// Checks input and output hold, busy after accept, compare results and reset.
// ----------------------------------------------------------------------------
module ramr_checker
    import ramr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_in,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_out
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_in))
        else $error("Stalled input item changed or was withdrawn.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("Stalled result changed or was dropped.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Block did not turn busy after taking an item.");

    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.equal |-> (o_out.res_num == '0) && (o_out.res_den == '0))
        else $error("Compare result carries a nonzero fraction.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

endmodule

bind rational_add_mul_reduce ramr_checker u_ramr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Rational add/multiply/reduce testbench
// Sends directed and random fraction pairs through the block under varying
// sender and receiver idling. A scoreboard predicts each reduced fraction
// and compares every returned item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import ramr_pkg::*;

    localparam int ITEMS_PER_PHASE = 345;
    localparam int HOLD_CYCLES     = 700;
    localparam int SETTLE_CYCLES   = 200;
    localparam int RUN_LIMIT       = 16_000_000;

    class fraction_scoreboard;
        t_out_item expected_fracs[$];
        int        mismatches = 0;

        function int outstanding();
            return expected_fracs.size();
        endfunction

        function t_out_item reduced_result(t_in_item x);
            t_out_item   y;
            logic [63:0] n;
            logic [63:0] d;
            logic [63:0] g;
            logic [63:0] r;
            logic [63:0] t;
            y = '0;
            n = '0;
            d = '0;
            case (x.cmd)
                CMD_ADD: begin
                    n = 64'(x.a_num) * 64'(x.b_den) + 64'(x.a_den) * 64'(x.b_num);
                    d = 64'(x.a_den) * 64'(x.b_den);
                end
                CMD_MUL: begin
                    n = 64'(x.a_num) * 64'(x.b_num);
                    d = 64'(x.a_den) * 64'(x.b_den);
                end
                CMD_CMP: begin
                    y.equal = (x.a_num == x.b_num) && (x.a_den == x.b_den);
                end
                default: begin
                end
            endcase
            if (n != 0 && d != 0) begin
                g = n;
                r = d;
                while (r != 0) begin
                    t = g % r;
                    g = r;
                    r = t;
                end
                n = n / g;
                d = d / g;
            end
            y.res_num = n[NUM_W-1:0];
            y.res_den = d[DEN_W-1:0];
            return y;
        endfunction

        function void note_input(t_in_item x);
            expected_fracs.push_back(reduced_result(x));
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_fracs.size() == 0) begin
                report_mismatch($sformatf("unexpected item num=%0d den=%0d equal=%0b",
                                          got.res_num, got.res_den, got.equal));
                return;
            end
            want = expected_fracs.pop_front();
            if (got.res_num !== want.res_num) begin
                report_mismatch($sformatf("res_num got %0d expected %0d",
                                          got.res_num, want.res_num));
            end
            if (got.res_den !== want.res_den) begin
                report_mismatch($sformatf("res_den got %0d expected %0d",
                                          got.res_den, want.res_den));
            end
            if (got.equal !== want.equal) begin
                report_mismatch($sformatf("equal got %0b expected %0b",
                                          got.equal, want.equal));
            end
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_in    = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_out;

    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    logic      hold_req    = 1'b0;
    logic      hold_ack    = 1'b0;
    int        hold_left   = 0;

    fraction_scoreboard sb;

    rational_add_mul_reduce uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_input(i_in);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_out);
            end
        end
    end

    function automatic t_in_item frac_pair(t_cmd cmd, int an, int ad, int bn, int bd);
        t_in_item x;
        x.cmd   = cmd;
        x.a_num = OPERAND_WIDTH'(an);
        x.a_den = OPERAND_WIDTH'(ad);
        x.b_num = OPERAND_WIDTH'(bn);
        x.b_den = OPERAND_WIDTH'(bd);
        return x;
    endfunction

    function automatic logic [OPERAND_WIDTH-1:0] pick_operand(bit nonzero);
        int unsigned              sel;
        logic [OPERAND_WIDTH-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            v = OPERAND_WIDTH'($urandom);
        end else if (sel < 70) begin
            v = OPERAND_WIDTH'($urandom_range(1, 64));
        end else if (sel < 95) begin
            v = OPERAND_WIDTH'($urandom_range(1, 255) * $urandom_range(1, 255));
        end else begin
            v = ($urandom_range(0, 1) == 0) ? '1 : OPERAND_WIDTH'(1);
        end
        if (nonzero && v == '0) begin
            v = OPERAND_WIDTH'(1);
        end
        return v;
    endfunction

    function automatic t_in_item random_pair();
        t_in_item    x;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            x.cmd = CMD_NONE;
        end else if (sel < 20) begin
            x.cmd = CMD_CMP;
        end else if (sel < 60) begin
            x.cmd = CMD_ADD;
        end else begin
            x.cmd = CMD_MUL;
        end
        x.a_num = pick_operand(1'b0);
        x.a_den = pick_operand(1'b1);
        x.b_num = pick_operand(1'b0);
        x.b_den = pick_operand(1'b1);
        if ($urandom_range(0, 19) == 0) begin
            x.a_num = '0;
        end
        if ($urandom_range(0, 19) == 0) begin
            x.b_num = '0;
        end
        if ($urandom_range(0, 49) == 0) begin
            x.b_den = '0;
        end
        if (x.cmd == CMD_CMP && $urandom_range(0, 9) < 4) begin
            x.b_num = x.a_num;
            x.b_den = x.a_den;
        end
        return x;
    endfunction

    task automatic send_item(input t_in_item item);
        i_valid <= 1'b1;
        i_in    <= item;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic sender_gap();
        int unsigned n;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        #RUN_LIMIT;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_in_item directed[$];
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct <= 36;
        rx_idle_pct <= 56;
        @(posedge i_clk);

        // Extremes, every command, zero numerators, zero denominators and
        // the unused command code.
        directed.push_back(frac_pair(CMD_ADD, 65535, 65535, 65535, 65535));
        directed.push_back(frac_pair(CMD_ADD, 65535, 1, 65535, 1));
        directed.push_back(frac_pair(CMD_ADD, 65535, 65534, 65535, 65533));
        directed.push_back(frac_pair(CMD_MUL, 65535, 1, 65535, 1));
        directed.push_back(frac_pair(CMD_MUL, 1, 65535, 1, 65535));
        directed.push_back(frac_pair(CMD_MUL, 65535, 65534, 65533, 65535));
        directed.push_back(frac_pair(CMD_ADD, 0, 5, 0, 7));
        directed.push_back(frac_pair(CMD_MUL, 0, 3, 9, 4));
        directed.push_back(frac_pair(CMD_ADD, 3, 0, 2, 5));
        directed.push_back(frac_pair(CMD_MUL, 3, 4, 5, 0));
        directed.push_back(frac_pair(CMD_ADD, 0, 0, 0, 0));
        directed.push_back(frac_pair(CMD_NONE, 1234, 77, 4321, 99));
        directed.push_back(frac_pair(CMD_NONE, 65535, 65535, 65535, 65535));
        directed.push_back(frac_pair(CMD_CMP, 1234, 5678, 1234, 5678));
        directed.push_back(frac_pair(CMD_CMP, 1234, 5678, 1235, 5678));
        directed.push_back(frac_pair(CMD_CMP, 1234, 5678, 1234, 5679));
        directed.push_back(frac_pair(CMD_CMP, 0, 0, 0, 0));
        directed.push_back(frac_pair(CMD_CMP, 65535, 65535, 65535, 65535));
        directed.push_back(frac_pair(CMD_ADD, 1, 2, 1, 2));
        directed.push_back(frac_pair(CMD_ADD, 1, 3, 1, 6));
        directed.push_back(frac_pair(CMD_MUL, 6, 4, 10, 15));
        directed.push_back(frac_pair(CMD_ADD, 1, 1, 0, 1));
        foreach (directed[k]) begin
            send_item(directed[k]);
            sender_gap();
        end
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct <= 36;
                    rx_idle_pct <= 56;
                end
                1: begin
                    tx_idle_pct <= 56;
                    rx_idle_pct <= 36;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            @(posedge i_clk);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 2 && k == 100) begin
                    hold_req <= ~hold_req;
                end
                send_item(random_pair());
                sender_gap();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
